// ===== src/fm_operator_volume_scaler_macros.svh =====
// ---------------------------------------------------------------------------
// FM operator volume scaler assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef FM_OPERATOR_VOLUME_SCALER_MACROS_SVH
`define FM_OPERATOR_VOLUME_SCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FMOVS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmovs assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FMOVS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmovs assertion failed");

// Next-cycle implication that also holds across reset.
`define FMOVS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fmovs assertion failed");

`endif

// ===== src/fmovs_pkg.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler package
// Widths, word types, register map and the volume curve threshold tables.
// ---------------------------------------------------------------------------
package fmovs_pkg;

   localparam int LevelW    = 7;
   localparam int MaskW     = 4;
   localparam int OpCount   = 4;
   localparam int HalfW     = 2 * LevelW;
   localparam int ProdW     = 4 * LevelW;
   localparam int StepCount = 63;
   localparam int CountW    = 6;
   localparam int LinDivisor = 4096766;

   localparam logic [LevelW-1:0] LevelMax  = 7'd127;
   localparam logic [LevelW-1:0] LinOffset = 7'd64;

   // Register map: one 32-bit register per word address.
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic RegVolumeModel = 1'b0;

   // Curve select codes.
   localparam logic ModelLog = 1'b0;
   localparam logic ModelLin = 1'b1;

   typedef logic [LevelW-1:0] level_type;
   typedef logic [ProdW-1:0]  prod_type;
   typedef prod_type          step_table_type [StepCount];

   typedef struct packed {
      level_type              velocity;
      level_type              master_level;
      level_type              channel_level;
      level_type              expression_level;
      logic [MaskW-1:0]       scale_mask;
      level_type              op_level_0;
      level_type              op_level_1;
      level_type              op_level_2;
      level_type              op_level_3;
   } req_word_type;

   typedef struct packed {
      level_type              out_level_0;
      level_type              out_level_1;
      level_type              out_level_2;
      level_type              out_level_3;
   } rsp_word_type;

   // Operator fields that ride along with the volume computation.
   typedef struct packed {
      logic [MaskW-1:0]              mask;
      level_type [OpCount-1:0]       levels;
   } op_set_type;

   typedef struct packed {
      prod_type               prod;
      op_set_type             ops;
   } prod_word_type;

   typedef struct packed {
      level_type              vol;
      op_set_type             ops;
   } vol_word_type;

   // Entry k is the smallest product that reaches log step k+1, i.e.
   // ceil(2^((k + 1 + 160.1379199767093) / 8)). The first entry already lies
   // above the logarithmic floor product, so no separate floor test is needed.
   localparam step_table_type LogThreshold = '{
      28'd1157227,   28'd1261965,   28'd1376183,   28'd1500738,   28'd1636566,
      28'd1784688,   28'd1946216,   28'd2122363,   28'd2314454,   28'd2523930,
      28'd2752365,   28'd3001475,   28'd3273132,   28'd3569375,   28'd3892431,
      28'd4244726,   28'd4628907,   28'd5047859,   28'd5504729,   28'd6002950,
      28'd6546263,   28'd7138750,   28'd7784862,   28'd8489452,   28'd9257814,
      28'd10095717,  28'd11009458,  28'd12005899,  28'd13092525,  28'd14277500,
      28'd15569724,  28'd16978904,  28'd18515627,  28'd20191434,  28'd22018915,
      28'd24011797,  28'd26185050,  28'd28554999,  28'd31139448,  28'd33957808,
      28'd37031253,  28'd40382867,  28'd44037829,  28'd48023593,  28'd52370100,
      28'd57109998,  28'd62278895,  28'd67915616,  28'd74062505,  28'd80765734,
      28'd88075658,  28'd96047186,  28'd104740199, 28'd114219996, 28'd124557789,
      28'd135831232, 28'd148125009, 28'd161531468, 28'd176151315, 28'd192094371,
      28'd209480397, 28'd228439992, 28'd249115578
   };

   // Entry k is (k+1) times the linear divisor; counting the entries at or
   // below the product gives the floored quotient.
   function automatic step_table_type lin_table();
      step_table_type t;
      for (int k = 0; k < StepCount; k++) begin
         t[k] = ProdW'((k + 1) * LinDivisor);
      end
      return t;
   endfunction

   localparam step_table_type LinThreshold = lin_table();

endpackage

// ===== src/fmovs_intf.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler channels
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
interface fmovs_req_intf;
   logic                    valid;
   logic                    ready;
   fmovs_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fmovs_rsp_intf;
   logic                    valid;
   logic                    ready;
   fmovs_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fmovs_product.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler product stages
// Two pipeline stages forming the 28-bit product of the four levels.
// ---------------------------------------------------------------------------
module fmovs_product (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  fmovs_pkg::req_word_type  in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output fmovs_pkg::prod_word_type out_word
);

   logic                                  a_valid_ff, a_valid_in;
   logic [fmovs_pkg::HalfW-1:0]           a_pair0_ff, a_pair1_ff;
   fmovs_pkg::op_set_type                 a_ops_ff;
   logic                                  b_valid_ff, b_valid_in;
   fmovs_pkg::prod_word_type              b_word_ff;
   logic                                  a_ready, b_ready;
   fmovs_pkg::op_set_type                 in_ops;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign in_ops.mask      = in_word.scale_mask;
   assign in_ops.levels[0] = in_word.op_level_0;
   assign in_ops.levels[1] = in_word.op_level_1;
   assign in_ops.levels[2] = in_word.op_level_2;
   assign in_ops.levels[3] = in_word.op_level_3;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
      end
      b_valid_in = b_valid_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_pair0_ff <= fmovs_pkg::HalfW'(in_word.velocity)
                     * fmovs_pkg::HalfW'(in_word.master_level);
         a_pair1_ff <= fmovs_pkg::HalfW'(in_word.channel_level)
                     * fmovs_pkg::HalfW'(in_word.expression_level);
         a_ops_ff   <= in_ops;
      end
      if (b_ready && a_valid_ff) begin
         b_word_ff.prod <= fmovs_pkg::ProdW'(a_pair0_ff) * fmovs_pkg::ProdW'(a_pair1_ff);
         b_word_ff.ops  <= a_ops_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

// ===== src/fmovs_curve.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler curve stages
// Threshold compare stage and step count stage that map the product to a
// volume of 0..127 on the logarithmic or linear curve.
// ---------------------------------------------------------------------------
module fmovs_curve (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     volume_model,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  fmovs_pkg::prod_word_type in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output fmovs_pkg::vol_word_type  out_word
);

   logic                                  c_valid_ff, c_valid_in;
   logic [fmovs_pkg::StepCount-1:0]       c_steps_ff, c_steps_in;
   logic                                  c_model_ff;
   fmovs_pkg::op_set_type                 c_ops_ff;
   logic                                  d_valid_ff, d_valid_in;
   fmovs_pkg::vol_word_type               d_word_ff;
   logic                                  c_ready, d_ready;
   logic [fmovs_pkg::CountW-1:0]          step_count;
   fmovs_pkg::level_type                  vol;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // One comparator per threshold; the result is a thermometer code.
   always_comb begin
      for (int k = 0; k < fmovs_pkg::StepCount; k++) begin
         if (volume_model == fmovs_pkg::ModelLin) begin
            c_steps_in[k] = in_word.prod >= fmovs_pkg::LinThreshold[k];
         end else begin
            c_steps_in[k] = in_word.prod >= fmovs_pkg::LogThreshold[k];
         end
      end
   end

   always_comb begin
      step_count = '0;
      for (int k = 0; k < fmovs_pkg::StepCount; k++) begin
         step_count = step_count + fmovs_pkg::CountW'(c_steps_ff[k]);
      end
   end

   // Both curves stay within 0..127 by construction: at most 126 on the
   // logarithmic curve and 63 + 64 on the linear one.
   always_comb begin
      if (c_model_ff == fmovs_pkg::ModelLin) begin
         if (step_count == '0) begin
            vol = '0;
         end else begin
            vol = fmovs_pkg::LevelW'(step_count) + fmovs_pkg::LinOffset;
         end
      end else begin
         vol = {step_count, 1'b0};
      end
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      if (c_ready) begin
         c_valid_in = in_valid;
      end
      d_valid_in = d_valid_ff;
      if (d_ready) begin
         d_valid_in = c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_steps_ff <= c_steps_in;
         c_model_ff <= volume_model;
         c_ops_ff   <= in_word.ops;
      end
      if (d_ready && c_valid_ff) begin
         d_word_ff.vol <= vol;
         d_word_ff.ops <= c_ops_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_word  = d_word_ff;

endmodule

// ===== src/fmovs_scale.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler operator stages
// Multiply stage and divide-by-127 stage that rescale each selected
// operator attenuation; the last stage is the response output register.
// ---------------------------------------------------------------------------
module fmovs_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  fmovs_pkg::vol_word_type  in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output fmovs_pkg::rsp_word_type  out_word
);

   logic                                          e_valid_ff, e_valid_in;
   logic [fmovs_pkg::OpCount-1:0][fmovs_pkg::HalfW-1:0] e_prod_ff;
   fmovs_pkg::op_set_type                         e_ops_ff;
   logic                                          f_valid_ff, f_valid_in;
   fmovs_pkg::level_type [fmovs_pkg::OpCount-1:0] f_level_ff, f_level_in;
   logic                                          e_ready, f_ready;
   logic [fmovs_pkg::OpCount-1:0][fmovs_pkg::HalfW-1:0] e_prod_in;

   assign f_ready  = !f_valid_ff || out_ready;
   assign e_ready  = !e_valid_ff || f_ready;
   assign in_ready = e_ready;

   always_comb begin
      for (int i = 0; i < fmovs_pkg::OpCount; i++) begin
         e_prod_in[i] = fmovs_pkg::HalfW'(in_word.vol)
                      * fmovs_pkg::HalfW'(fmovs_pkg::LevelMax - in_word.ops.levels[i]);
      end
   end

   // Floor division by 127: x / 128 undershoots by less than one, and the
   // remainder (x mod 128) + x / 128 stays below 254, so one compare fixes it.
   always_comb begin
      logic [fmovs_pkg::LevelW-1:0] q0;
      logic [fmovs_pkg::LevelW:0]   rem;
      fmovs_pkg::level_type         quot;
      for (int i = 0; i < fmovs_pkg::OpCount; i++) begin
         q0   = e_prod_ff[i][fmovs_pkg::HalfW-1:fmovs_pkg::LevelW];
         rem  = {1'b0, e_prod_ff[i][fmovs_pkg::LevelW-1:0]} + {1'b0, q0};
         quot = q0;
         if (rem >= {1'b0, fmovs_pkg::LevelMax}) begin
            quot = q0 + 1'b1;
         end
         if (e_ops_ff.mask[i]) begin
            f_level_in[i] = fmovs_pkg::LevelMax - quot;
         end else begin
            f_level_in[i] = e_ops_ff.levels[i];
         end
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (e_ready) begin
         e_valid_in = in_valid;
      end
      f_valid_in = f_valid_ff;
      if (f_ready) begin
         f_valid_in = e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && in_valid) begin
         e_prod_ff <= e_prod_in;
         e_ops_ff  <= in_word.ops;
      end
      if (f_ready && e_valid_ff) begin
         f_level_ff <= f_level_in;
      end
   end

   assign out_valid            = f_valid_ff;
   assign out_word.out_level_0 = f_level_ff[0];
   assign out_word.out_level_1 = f_level_ff[1];
   assign out_word.out_level_2 = f_level_ff[2];
   assign out_word.out_level_3 = f_level_ff[3];

endmodule

// ===== src/fm_operator_volume_scaler.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler
// Combines four MIDI levels into one volume and rescales the selected
// operator attenuations, in a six-stage valid/ready pipeline.
// ---------------------------------------------------------------------------
// The block accepts one request word per cycle while the output is not stalled
// and returns one response word for each, in order. The depth is set by the
// chain multiply (two stages), the 63-way threshold compare and step count
// that form the volume curve (two stages), and the operator multiply and
// divide by 127 (two stages). Every stage holds its word while the next one
// is full, so backpressure loses nothing.
// The volume_model register at byte address 0 selects the logarithmic (0)
// or linear (1) curve and should only be written while the pipeline is empty.
module fm_operator_volume_scaler (
   input  logic                             clock,
   input  logic                             reset,
   fmovs_req_intf.sink                      req_if,
   fmovs_rsp_intf.source                    rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fmovs_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [fmovs_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [fmovs_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic                      volume_model_ff, volume_model_in;
   logic                      csr_write;
   logic                      csr_index;
   logic                      prod_valid, prod_ready;
   fmovs_pkg::prod_word_type  prod_word;
   logic                      vol_valid, vol_ready;
   fmovs_pkg::vol_word_type   vol_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      volume_model_in = volume_model_ff;
      if (csr_write && csr_index == fmovs_pkg::RegVolumeModel) begin
         volume_model_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_model_ff <= fmovs_pkg::ModelLog;
      end else begin
         volume_model_ff <= volume_model_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == fmovs_pkg::RegVolumeModel) begin
         csr_prdata[0] = volume_model_ff;
      end
   end

   fmovs_product u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_word   (req_if.data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_word  (prod_word)
   );

   fmovs_curve u_curve (
      .clock        (clock),
      .reset        (reset),
      .volume_model (volume_model_ff),
      .in_valid     (prod_valid),
      .in_ready     (prod_ready),
      .in_word      (prod_word),
      .out_valid    (vol_valid),
      .out_ready    (vol_ready),
      .out_word     (vol_word)
   );

   fmovs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vol_valid),
      .in_ready  (vol_ready),
      .in_word   (vol_word),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (rsp_if.data)
   );

endmodule

// ===== src/fmovs_checker.sv =====
// ---------------------------------------------------------------------------
// FM operator volume scaler port checker
// Watches the request and response channels of the top level over time.
// ---------------------------------------------------------------------------
`include "fm_operator_volume_scaler_macros.svh"

module fmovs_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_ready,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  fmovs_pkg::rsp_word_type rsp_data
);

   // A stalled response word stays up and unchanged.
   `FMOVS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FMOVS_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))

   // With the sink taking words, every stage can move, so the input is open.
   `FMOVS_ASSERT_IMP(a_flow_through, clock, reset, rsp_ready, req_ready)

   // Reset empties the pipeline: no response word right after it.
   `FMOVS_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind fm_operator_volume_scaler fmovs_checker u_fmovs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

// ===== verif/fmovs_scoreboard.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FM operator volume scaler checker
// Watches the request, response and register ports, predicts the scaled
// operator levels of every accepted request word and compares each response
// word with the oldest prediction.
// ---------------------------------------------------------------------------
module fmovs_scoreboard (
   input  logic                             clock,
   input  logic                             reset,
   fmovs_req_intf                           req_if,
   fmovs_rsp_intf                           rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fmovs_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [fmovs_pkg::CsrDataW-1:0]   csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending
);
   import fmovs_pkg::*;

   localparam int unsigned LogFloor  = 1108075;
   localparam int unsigned LinScale  = 4096766;
   localparam int unsigned LinBase   = 64;
   localparam int unsigned LevelTop  = 127;
   localparam int          CurveSteps = 63;

   // Smallest product that reaches each step of the logarithmic curve.
   int unsigned log_step [CurveSteps] = '{
      1157227,   1261965,   1376183,   1500738,   1636566,   1784688,   1946216,
      2122363,   2314454,   2523930,   2752365,   3001475,   3273132,   3569375,
      3892431,   4244726,   4628907,   5047859,   5504729,   6002950,   6546263,
      7138750,   7784862,   8489452,   9257814,   10095717,  11009458,  12005899,
      13092525,  14277500,  15569724,  16978904,  18515627,  20191434,  22018915,
      24011797,  26185050,  28554999,  31139448,  33957808,  37031253,  40382867,
      44037829,  48023593,  52370100,  57109998,  62278895,  67915616,  74062505,
      80765734,  88075658,  96047186,  104740199, 114219996, 124557789, 135831232,
      148125009, 161531468, 176151315, 192094371, 209480397, 228439992, 249115578
   };

   rsp_word_type expected_levels [$];
   logic         curve_model = ModelLog;
   int           mismatch_count = 0;

   function automatic level_type curve_volume(input int unsigned prod, input logic model);
      int unsigned vol;
      vol = 0;
      if (model == ModelLin) begin
         vol = prod / LinScale;
         if (vol != 0) begin
            vol += LinBase;
         end
      end else if (prod > LogFloor) begin
         for (int k = 0; k < CurveSteps; k++) begin
            if (prod >= log_step[k]) begin
               vol += 2;
            end
         end
      end
      if (vol > LevelTop) begin
         vol = LevelTop;
      end
      return level_type'(vol);
   endfunction

   function automatic level_type rescale(input level_type vol, input level_type tl,
                                         input logic enable);
      int unsigned atten;
      if (!enable) begin
         return tl;
      end
      atten = LevelTop - (int'(vol) * (LevelTop - int'(tl))) / LevelTop;
      return level_type'(atten);
   endfunction

   function automatic rsp_word_type scale_levels(input req_word_type w, input logic model);
      int unsigned  prod;
      level_type    vol;
      rsp_word_type r;
      prod = int'(w.velocity) * int'(w.master_level) * int'(w.channel_level)
             * int'(w.expression_level);
      vol = curve_volume(prod, model);
      r.out_level_0 = rescale(vol, w.op_level_0, w.scale_mask[0]);
      r.out_level_1 = rescale(vol, w.op_level_1, w.scale_mask[1]);
      r.out_level_2 = rescale(vol, w.op_level_2, w.scale_mask[2]);
      r.out_level_3 = rescale(vol, w.op_level_3, w.scale_mask[3]);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : track_words
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         expected_levels.delete();
         curve_model = ModelLog;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[CsrAddrW-1:2] == RegVolumeModel) begin
            curve_model = csr_pwdata[0];
         end
         if (req_if.valid && req_if.ready) begin
            expected_levels.push_back(scale_levels(req_if.data, curve_model));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (expected_levels.size() == 0) begin
               report_mismatch("response word arrived with no request waiting");
            end else begin
               want = expected_levels.pop_front();
               if (got.out_level_0 !== want.out_level_0)
                  report_mismatch($sformatf("out_level_0 got %0d expected %0d",
                                            got.out_level_0, want.out_level_0));
               if (got.out_level_1 !== want.out_level_1)
                  report_mismatch($sformatf("out_level_1 got %0d expected %0d",
                                            got.out_level_1, want.out_level_1));
               if (got.out_level_2 !== want.out_level_2)
                  report_mismatch($sformatf("out_level_2 got %0d expected %0d",
                                            got.out_level_2, want.out_level_2));
               if (got.out_level_3 !== want.out_level_3)
                  report_mismatch($sformatf("out_level_3 got %0d expected %0d",
                                            got.out_level_3, want.out_level_3));
            end
         end
      end
      pending    <= expected_levels.size();
      fail_count <= mismatch_count;
   end

endmodule

// ===== verif/tb_fm_operator_volume_scaler.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FM operator volume scaler testbench
// Drives directed and random request words under both volume curves, with
// random stalls on both channels, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_fm_operator_volume_scaler;
   import fmovs_pkg::*;

   localparam int   CycleLimit  = 400000;
   localparam int   DrainCycles = 20;
   localparam logic RegUnused   = 1'b1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0]  csr_paddr = '0;
   logic [CsrDataW-1:0]  csr_pwdata = '0;
   logic [CsrDataW-1:0]  csr_prdata;
   logic                 csr_pready;

   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   gap_pct = 0;
   logic quiet = 1'b0;

   fmovs_req_intf req_if ();
   fmovs_rsp_intf rsp_if ();

   fm_operator_volume_scaler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fmovs_scoreboard u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: ready stretches alternate with stall bursts.
   initial begin : rsp_stall
      int n;
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_if.ready <= 1'b1;
            n = $urandom_range(1, 40);
         end else begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 19);
         end
         repeat (n) @(posedge clock);
      end
   end

   function automatic req_word_type make_req(input int vel, input int mst, input int chv,
                                             input int exv, input int mask, input int o0,
                                             input int o1, input int o2, input int o3);
      req_word_type w;
      w.velocity         = level_type'(vel);
      w.master_level     = level_type'(mst);
      w.channel_level    = level_type'(chv);
      w.expression_level = level_type'(exv);
      w.scale_mask       = MaskW'(mask);
      w.op_level_0       = level_type'(o0);
      w.op_level_1       = level_type'(o1);
      w.op_level_2       = level_type'(o2);
      w.op_level_3       = level_type'(o3);
      return w;
   endfunction

   // Levels lean toward the ends of the range so both curves see low and high products.
   function automatic int pick_level();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 40);
         1:       return $urandom_range(90, 127);
         2:       return $urandom_range(0, 1) * 127;
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   function automatic req_word_type random_req();
      return make_req(pick_level(), pick_level(), pick_level(), pick_level(),
                      $urandom_range(0, 15), pick_level(), pick_level(),
                      pick_level(), pick_level());
   endfunction

   task automatic send_req(input req_word_type w);
      int gap;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      req_if.data  <= w;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Waits until every predicted word has come back and the pipeline is empty.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [CsrDataW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 10;
               default: gap_pct = 35;
            endcase
         end
         send_req(random_req());
      end
   endtask

   initial begin : stimulus
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Logarithmic curve from the reset value.
      gap_pct = 20;
      send_req(make_req(0, 0, 0, 0, 15, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 15, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 15, 127, 127, 127, 127));
      send_req(make_req(127, 127, 127, 127, 0, 5, 60, 100, 127));
      // Just below the floor product, then just past the first step.
      send_req(make_req(32, 32, 32, 32, 15, 0, 1, 2, 3));
      send_req(make_req(33, 33, 33, 33, 15, 0, 1, 2, 3));
      send_req(make_req(127, 127, 127, 127, 1, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 2, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 4, 127, 127, 127, 127));
      send_req(make_req(127, 127, 127, 127, 8, 64, 64, 64, 64));
      send_req(make_req(1, 127, 127, 127, 15, 0, 0, 0, 0));
      send_req(make_req(90, 100, 110, 120, 10, 10, 20, 30, 40));
      drain();

      // Upper register bits set: only the curve select bit counts.
      csr_write(RegVolumeModel, {31'h7fff_ffff, ModelLin});
      send_req(make_req(0, 0, 0, 0, 15, 0, 0, 0, 0));
      // Products just below and just above the linear divisor.
      send_req(make_req(44, 44, 44, 44, 15, 0, 0, 0, 0));
      send_req(make_req(45, 45, 45, 45, 15, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 15, 0, 0, 0, 0));
      send_req(make_req(127, 127, 127, 127, 5, 0, 127, 0, 127));
      send_req(make_req(127, 127, 127, 127, 10, 0, 127, 0, 127));
      send_req(make_req(127, 127, 127, 127, 15, 127, 127, 127, 127));
      send_req(make_req(100, 120, 127, 90, 15, 33, 66, 99, 1));
      send_random(400);
      drain();

      // A write to an unmapped register must leave the curve alone.
      csr_write(RegUnused, {31'h0, ModelLog});
      send_random(100);
      drain();

      csr_write(RegVolumeModel, {31'h7fff_ffff, ModelLog});
      send_random(400);
      drain();

      csr_write(RegVolumeModel, {31'h0, ModelLin});
      send_random(200);
      drain();

      csr_write(RegVolumeModel, {31'h0, ModelLog});
      quiet = 1'b1;
      send_random(200);
      drain();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
